>>> hw/rtl/pst_pkg.sv
package pst_pkg;

  localparam int unsigned NUM_W = 16;
  localparam int unsigned CFG_W = 17;
  localparam logic [CFG_W-1:0] SIEVE_LIMIT_RST = 17'd65536;

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic REG_SIEVE_LIMIT = 1'b0;

  typedef struct packed {
    logic             operation;
    logic [NUM_W-1:0] number;
  } pst_item_t;

  typedef struct packed {
    logic is_prime;
    logic out_of_range;
    logic build_done;
  } pst_result_t;

  typedef struct packed {
    logic query;
    logic build_go;
    logic init_wr;
    logic y_load;
    logic test_rd;
    logic y_next;
    logic m_load;
    logic mark_wr;
    logic finish;
  } pst_cmd_t;

  typedef struct packed {
    logic init_last;
    logic y_stop;
    logic flag;
    logic m_end;
  } pst_status_t;

endpackage

>>> hw/rtl/pst_datapath.sv
module pst_datapath import pst_pkg::*; #(
  parameter int unsigned MAX_LIMIT = 65536
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CFG_W-1:0] sieve_limit_i,
  input  logic [NUM_W-1:0] number_i,
  input  pst_cmd_t         cmd_i,
  output pst_status_t      status_o,
  output logic             res_valid_o,
  output pst_result_t      res_o
);

  localparam int unsigned AW = $clog2(MAX_LIMIT);
  localparam int unsigned LW = AW + 1;
  localparam int unsigned SW = AW + 2;
  localparam int unsigned CW = (LW > CFG_W) ? LW : CFG_W;

  logic [CW-1:0] lim_w;
  logic [CW-1:0] max_w;
  logic [CW-1:0] eff_w;
  logic [CW-1:0] num_w;
  logic [LW-1:0] lim;
  logic          in_range;
  logic          ge2;

  logic [LW-1:0] idx_q;
  logic [LW-1:0] y_q;
  logic [SW-1:0] ysq_q;
  logic [SW-1:0] m_q;

  logic          init_bit;
  logic          we;
  logic [AW-1:0] wa;
  logic          wd;
  logic          re;
  logic [AW-1:0] ra;

  logic          mem_q [MAX_LIMIT];
  logic          rd_q;

  logic          built_q;
  logic          res_valid_q;
  logic          qok_q;
  logic          oor_q;
  logic          done_q;

  assign lim_w    = CW'(sieve_limit_i);
  assign max_w    = CW'(MAX_LIMIT);
  assign eff_w    = (lim_w > max_w) ? max_w : lim_w;
  assign lim      = eff_w[LW-1:0];
  assign num_w    = CW'(number_i);
  assign in_range = num_w < eff_w;
  assign ge2      = number_i >= NUM_W'(2);

  assign init_bit = (idx_q >= LW'(2)) && (idx_q < lim);

  assign status_o.init_last = idx_q == LW'(MAX_LIMIT - 1);
  assign status_o.y_stop    = (ysq_q > SW'(lim)) || (y_q >= lim);
  assign status_o.flag      = rd_q;
  assign status_o.m_end     = m_q >= SW'(lim);

  assign we = cmd_i.init_wr | cmd_i.mark_wr;
  assign wa = cmd_i.init_wr ? idx_q[AW-1:0] : m_q[AW-1:0];
  assign wd = cmd_i.init_wr ? init_bit : 1'b0;
  assign re = cmd_i.query | cmd_i.test_rd;
  assign ra = cmd_i.query ? num_w[AW-1:0] : y_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem_q[ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.build_go) begin
      idx_q <= '0;
    end else if (cmd_i.init_wr) begin
      idx_q <= idx_q + LW'(1);
    end
    if (cmd_i.y_load) begin
      y_q   <= LW'(2);
      ysq_q <= SW'(4);
    end else if (cmd_i.y_next) begin
      y_q   <= y_q + LW'(1);
      ysq_q <= ysq_q + {y_q, 1'b1};
    end
    if (cmd_i.m_load) begin
      m_q <= {y_q, 1'b0};
    end else if (cmd_i.mark_wr) begin
      m_q <= m_q + SW'(y_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      built_q     <= 1'b0;
      res_valid_q <= 1'b0;
      qok_q       <= 1'b0;
      oor_q       <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      if (cmd_i.build_go) begin
        built_q <= 1'b1;
      end
      res_valid_q <= cmd_i.query | cmd_i.finish;
      qok_q       <= cmd_i.query & in_range & ge2 & built_q;
      oor_q       <= cmd_i.query & ~in_range;
      done_q      <= cmd_i.finish;
    end
  end

  assign res_valid_o         = res_valid_q;
  assign res_o.is_prime      = qok_q & rd_q;
  assign res_o.out_of_range  = oor_q;
  assign res_o.build_done    = done_q;

endmodule

>>> hw/rtl/pst_controller.sv
module pst_controller import pst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        operation_i,
  input  pst_status_t status_i,
  output pst_cmd_t    cmd_o,
  output logic        busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_READ,
    S_TEST,
    S_MARK
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   busy_q;
  logic   busy_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    busy_d  = busy_q;
    unique case (state_q)
      S_IDLE: begin
        if (start && operation_i == OP_QUERY) begin
          cmd_o.query = 1'b1;
        end else if (start && operation_i == OP_BUILD) begin
          cmd_o.build_go = 1'b1;
          state_d        = S_INIT;
          busy_d         = 1'b1;
        end
      end
      S_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (status_i.init_last) begin
          cmd_o.y_load = 1'b1;
          state_d      = S_READ;
        end
      end
      S_READ: begin
        if (status_i.y_stop) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
          busy_d       = 1'b0;
        end else begin
          cmd_o.test_rd = 1'b1;
          state_d       = S_TEST;
        end
      end
      S_TEST: begin
        if (status_i.flag) begin
          cmd_o.m_load = 1'b1;
          state_d      = S_MARK;
        end else begin
          cmd_o.y_next = 1'b1;
          state_d      = S_READ;
        end
      end
      S_MARK: begin
        if (status_i.m_end) begin
          cmd_o.y_next = 1'b1;
          state_d      = S_READ;
        end else begin
          cmd_o.mark_wr = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
        busy_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy = busy_q;

endmodule

>>> hw/rtl/prime_sieve_table.sv
// A query word gives its result in the next cycle; queries may come every cycle while not busy.
// A build word first rewrites all MAX_LIMIT entries of the table, then reads and tests each
// candidate, clears the multiples of each prime it finds one at a time and ends with a finish step,
// all through the single write port of the table.
// The build result comes in the cycle busy falls. Results cannot be stalled.
// Reset makes the table read as all clear until the first build and sets sieve_limit to 65536.
module prime_sieve_table import pst_pkg::*; #(
  parameter int unsigned MAX_LIMIT = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  pst_item_t   item_i,
  output logic        res_valid_o,
  output pst_result_t res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CFG_W-1:0] sieve_limit_q;
  pst_cmd_t         cmd;
  pst_status_t      status;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sieve_limit_q <= SIEVE_LIMIT_RST;
    end else if (psel && penable && pwrite && paddr[2] == REG_SIEVE_LIMIT) begin
      sieve_limit_q <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_SIEVE_LIMIT) ? 32'(sieve_limit_q) : '0;

  pst_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (item_i.operation),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy        (busy)
  );

  pst_datapath #(
    .MAX_LIMIT (MAX_LIMIT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sieve_limit_i (sieve_limit_q),
    .number_i      (item_i.number),
    .cmd_i         (cmd),
    .status_o      (status),
    .res_valid_o   (res_valid_o),
    .res_o         (res_o)
  );

endmodule

>>> hw/rtl/pst_checker.sv
module pst_checker import pst_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input pst_item_t   item_i,
  input logic        res_valid_o,
  input pst_result_t res_o
);

  a_query_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.operation == OP_QUERY) |=> (res_valid_o && !res_o.build_done))
    else $error("query word did not give its result in the next cycle");

  a_build_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.operation == OP_BUILD) |=> busy)
    else $error("build word did not raise busy");

  a_build_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (res_valid_o && res_o.build_done))
    else $error("build finished without a done result");

  a_build_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.build_done) |-> (!res_o.is_prime && !res_o.out_of_range))
    else $error("build result carries query flags");

endmodule

bind prime_sieve_table pst_checker u_pst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .item_i      (item_i),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
